// ===== rtl/bba_pkg.sv =====
// Shared types, codes and defaults of the bitmap block allocator.
package bba_pkg;

  localparam int unsigned NUM_BLOCKS_DEF = 1048576;
  localparam int unsigned WORD_BITS_DEF  = 64;

  localparam int unsigned CMD_W   = 2;
  localparam int unsigned BLOCK_W = 20;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned COUNT_W = 21;

  localparam logic [COUNT_W-1:0] MANAGED_RESET = 21'd1048576;

  // Command codes. The unused code acts as a test.
  localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FREE  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TEST  = 2'd2;

  // Result status codes.
  localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL    = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FREED   = 2'd2;
  localparam logic [STAT_W-1:0] STAT_RANGE   = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [BLOCK_W-1:0] block_index;
  } bba_cmd_t;

  typedef struct packed {
    logic [BLOCK_W-1:0] result_block;
    logic [STAT_W-1:0]  status;
    logic               block_used;
    logic [COUNT_W-1:0] used_count;
  } bba_result_t;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } bba_mem_ctl_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_SPLIT,
    ST_APPLY
  } bba_state_e;

endpackage

// ===== rtl/bitmap_block_allocator_unit.sv =====
// First-fit bitmap block allocator: top level with the command sequencer.
//
// Commands enter on cmd_i when start is high and busy is low; each gives one result word on
// result_o, valid for exactly one cycle while done_o is high, and the receiver cannot stall.
// After reset the block clears its bitmap memory one word a cycle, so busy stays high until all
// ceil(NUM_BLOCKS / WORD_BITS) words (16384 at the defaults) are cleared, before the first command.
// An allocate scans the bitmap memory one word per cycle from word 0: each word read is checked
// when its registered read data returns, and the result is given when the first word with a
// free bit is checked, or as full when that bit lies at or beyond the managed limit or when no
// word is left to read below the limit. The scan through the memory read port sets its rate.
// A free or test goes through index split into word and bit, memory read and update, and
// an out-of-range free or test answers in the cycle after acceptance. The next
// command may be accepted in the cycle the result is shown. The managed_blocks register is
// written through cfg_valid_i / cfg_data_i at any time and should only change while no command
// is in flight.
module bitmap_block_allocator_unit #(
  parameter int unsigned NUM_BLOCKS = bba_pkg::NUM_BLOCKS_DEF,
  parameter int unsigned WORD_BITS  = bba_pkg::WORD_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  bba_pkg::bba_cmd_t                  cmd_i,
  output logic                               done_o,
  output bba_pkg::bba_result_t               result_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [bba_pkg::COUNT_W-1:0]        cfg_data_i
);
  import bba_pkg::*;

  localparam int unsigned MAP_WORDS = (NUM_BLOCKS + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int unsigned PW        = AW + 1;
  localparam int unsigned KW        = $clog2(WORD_BITS);
  localparam int unsigned BW        = $clog2(NUM_BLOCKS + WORD_BITS + 1);
  localparam int unsigned CW        = (BW > COUNT_W + 1) ? BW : COUNT_W + 1;
  // Floor reciprocal of WORD_BITS scaled by 2^BLOCK_W; the quotient estimate is low by at most 1.
  localparam logic [BLOCK_W-1:0] RECIP = BLOCK_W'((1 << BLOCK_W) / WORD_BITS);

  // Lowest zero bit of a word, found by halving the window six times.
  function automatic logic [5:0] first_zero(input logic [63:0] w);
    logic [63:0] inv;
    logic [63:0] sh;
    logic [5:0]  pos;
    inv = ~w;
    pos = '0;
    for (int lvl = 5; lvl >= 0; lvl--) begin
      sh = inv >> pos;
      if ((sh & ((64'd1 << (1 << lvl)) - 64'd1)) == 64'd0) begin
        pos = pos + 6'(1 << lvl);
      end
    end
    return pos;
  endfunction

  bba_state_e state_q, state_d;

  logic [PW-1:0]        ptr_q, ptr_d;
  logic [CW-1:0]        base_q, base_d;
  logic                 chk_vld_q, chk_vld_d;
  logic [CW-1:0]        chk_base_q, chk_base_d;
  logic [AW-1:0]        chk_addr_q, chk_addr_d;
  logic [COUNT_W-1:0]   count_q, count_d;
  logic [COUNT_W-1:0]   managed_q;
  logic                 done_q, done_d;
  bba_result_t          res_q, res_d;
  logic [CMD_W-1:0]     cmd_q, cmd_d;
  logic [BLOCK_W-1:0]   idx_q, idx_d;
  logic [BLOCK_W-1:0]   quot_q, quot_d;
  logic [AW-1:0]        word_q, word_d;
  logic [KW-1:0]        bit_q, bit_d;

  bba_mem_ctl_t         mem_ctl;
  logic [AW-1:0]        mem_waddr;
  logic [WORD_BITS-1:0] mem_wdata;
  logic [AW-1:0]        mem_raddr;
  logic [WORD_BITS-1:0] mem_rdata;

  logic [CW-1:0]        limit;
  logic [CW-1:0]        managed_ext;
  logic                 accept;
  logic                 out_of_range;
  logic [2*BLOCK_W-1:0] quot_prod;
  logic [COUNT_W-1:0]   rem_raw;
  logic                 rem_over;
  logic [BLOCK_W-1:0]   quot_fix;
  logic [COUNT_W-1:0]   rem_fix;
  logic                 can_issue;
  logic [63:0]          chk_word;
  logic [5:0]           fz;
  logic                 has_zero;
  logic [CW-1:0]        hit_blk;
  logic                 scan_hit;
  logic                 scan_full;
  logic                 named_bit;
  logic                 clear_last;

  bba_bitmap_ram #(
    .DEPTH (MAP_WORDS),
    .WIDTH (WORD_BITS),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .ctl_i   (mem_ctl),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign busy        = (state_q != ST_IDLE);
  assign accept      = start && !busy;
  assign cfg_ready_o = 1'b1;
  assign done_o      = done_q;
  assign result_o    = res_q;

  assign managed_ext  = CW'(managed_q);
  assign limit        = (managed_ext > CW'(NUM_BLOCKS)) ? CW'(NUM_BLOCKS) : managed_ext;
  assign out_of_range = (CW'(cmd_i.block_index) >= limit);

  // Word number of a named block by reciprocal multiply, corrected in the split state.
  assign quot_prod = (2*BLOCK_W)'(cmd_i.block_index) * (2*BLOCK_W)'(RECIP);
  assign rem_raw   = COUNT_W'(idx_q) - COUNT_W'(quot_q * WORD_BITS);
  assign rem_over  = (rem_raw >= COUNT_W'(WORD_BITS));
  assign quot_fix  = rem_over ? (quot_q + BLOCK_W'(1)) : quot_q;
  assign rem_fix   = rem_over ? (rem_raw - COUNT_W'(WORD_BITS)) : rem_raw;

  // Scan: a read goes out each cycle while the next word still starts below the limit; the
  // word read in the previous cycle is checked at the same time.
  assign can_issue = (ptr_q < PW'(MAP_WORDS)) && (base_q < limit);

  always_comb begin
    chk_word                 = '1;
    chk_word[WORD_BITS-1:0]  = mem_rdata;
  end

  assign fz        = first_zero(chk_word);
  assign has_zero  = ~&chk_word;
  assign hit_blk   = chk_base_q + CW'(fz);
  assign scan_hit  = chk_vld_q && has_zero && (hit_blk < limit);
  assign scan_full = (chk_vld_q && has_zero && !(hit_blk < limit)) || (!chk_vld_q && !can_issue);
  assign named_bit = mem_rdata[bit_q];
  assign clear_last = (ptr_q == PW'(MAP_WORDS - 1));

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (clear_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          if (cmd_i.cmd == CMD_ALLOC) begin
            state_d = ST_SCAN;
          end else if (!out_of_range) begin
            state_d = ST_SPLIT;
          end
        end
      end
      ST_SCAN: begin
        if (scan_hit || scan_full) state_d = ST_IDLE;
      end
      ST_SPLIT: state_d = ST_APPLY;
      ST_APPLY: state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Memory controls and datapath.
  always_comb begin
    ptr_d      = ptr_q;
    base_d     = base_q;
    chk_vld_d  = 1'b0;
    chk_base_d = chk_base_q;
    chk_addr_d = chk_addr_q;
    count_d    = count_q;
    done_d     = 1'b0;
    res_d      = res_q;
    cmd_d      = cmd_q;
    idx_d      = idx_q;
    quot_d     = quot_q;
    word_d     = word_q;
    bit_d      = bit_q;
    mem_ctl    = '0;
    mem_waddr  = word_q;
    mem_wdata  = mem_rdata;
    mem_raddr  = ptr_q[AW-1:0];

    unique case (state_q)
      ST_CLEAR: begin
        mem_ctl.wr_en = 1'b1;
        mem_waddr     = ptr_q[AW-1:0];
        mem_wdata     = '0;
        ptr_d         = ptr_q + PW'(1);
      end
      ST_IDLE: begin
        if (accept) begin
          cmd_d  = cmd_i.cmd;
          idx_d  = cmd_i.block_index;
          quot_d = quot_prod[2*BLOCK_W-1:BLOCK_W];
          ptr_d  = '0;
          base_d = '0;
          if (cmd_i.cmd != CMD_ALLOC && out_of_range) begin
            done_d             = 1'b1;
            res_d.result_block = cmd_i.block_index;
            res_d.status       = STAT_RANGE;
            res_d.block_used   = 1'b0;
            res_d.used_count   = count_q;
          end
        end
      end
      ST_SCAN: begin
        if (can_issue) begin
          mem_ctl.rd_en = 1'b1;
          mem_raddr     = ptr_q[AW-1:0];
          ptr_d         = ptr_q + PW'(1);
          base_d        = base_q + CW'(WORD_BITS);
          chk_vld_d     = 1'b1;
          chk_base_d    = base_q;
          chk_addr_d    = ptr_q[AW-1:0];
        end
        if (scan_hit) begin
          mem_ctl.wr_en      = 1'b1;
          mem_waddr          = chk_addr_q;
          mem_wdata          = mem_rdata | (WORD_BITS'(1) << fz[KW-1:0]);
          count_d            = count_q + COUNT_W'(1);
          done_d             = 1'b1;
          res_d.result_block = hit_blk[BLOCK_W-1:0];
          res_d.status       = STAT_OK;
          res_d.block_used   = 1'b1;
          res_d.used_count   = count_q + COUNT_W'(1);
        end else if (scan_full) begin
          done_d             = 1'b1;
          res_d.result_block = '0;
          res_d.status       = STAT_FULL;
          res_d.block_used   = 1'b0;
          res_d.used_count   = count_q;
        end
      end
      ST_SPLIT: begin
        mem_ctl.rd_en = 1'b1;
        mem_raddr     = quot_fix[AW-1:0];
        word_d        = quot_fix[AW-1:0];
        bit_d         = rem_fix[KW-1:0];
      end
      ST_APPLY: begin
        done_d             = 1'b1;
        res_d.result_block = idx_q;
        res_d.status       = STAT_OK;
        res_d.block_used   = 1'b0;
        res_d.used_count   = count_q;
        if (cmd_q == CMD_FREE) begin
          if (named_bit) begin
            mem_ctl.wr_en = 1'b1;
            mem_waddr     = word_q;
            mem_wdata     = mem_rdata & ~(WORD_BITS'(1) << bit_q);
            if (count_q != '0) begin
              count_d          = count_q - COUNT_W'(1);
              res_d.used_count = count_q - COUNT_W'(1);
            end
          end else begin
            res_d.status = STAT_FREED;
          end
        end else begin
          res_d.block_used = named_bit;
        end
      end
      default: begin
        mem_ctl = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      ptr_q     <= '0;
      base_q    <= '0;
      chk_vld_q <= 1'b0;
      count_q   <= '0;
      managed_q <= MANAGED_RESET;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      ptr_q     <= ptr_d;
      base_q    <= base_d;
      chk_vld_q <= chk_vld_d;
      count_q   <= count_d;
      done_q    <= done_d;
      if (cfg_valid_i && cfg_ready_o) begin
        managed_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    chk_base_q <= chk_base_d;
    chk_addr_q <= chk_addr_d;
    res_q      <= res_d;
    cmd_q      <= cmd_d;
    idx_q      <= idx_d;
    quot_q     <= quot_d;
    word_q     <= word_d;
    bit_q      <= bit_d;
  end

  // The bitmap is only written by the clearing pass or when a command finishes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_ctl.wr_en |-> (state_q == ST_CLEAR) || scan_hit || (state_q == ST_APPLY))
    else $error("bitmap written outside clear or command completion");

  // The use count moves only together with a result word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |-> done_q)
    else $error("use count changed without a result");

  // Every result word comes from an accepted command or a finishing scan or update.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(accept) || $past(state_q == ST_SCAN) || $past(state_q == ST_APPLY))
    else $error("result strobe without a command");

  // A full map reports block 0 as unused.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && res_q.status == STAT_FULL) |-> (res_q.result_block == '0) && !res_q.block_used)
    else $error("full status with a block");

  // The scan pointer never runs past the end of the map.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (ptr_q <= PW'(MAP_WORDS)))
    else $error("scan pointer beyond map");

endmodule

// ===== rtl/bba_bitmap_ram.sv =====
// Single-port-write, single-port-read bitmap memory with registered read data.
module bba_bitmap_ram #(
  parameter int unsigned DEPTH = 16384,
  parameter int unsigned WIDTH = 64,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                  clk_i,
  input  bba_pkg::bba_mem_ctl_t ctl_i,
  input  logic [AW-1:0]         waddr_i,
  input  logic [WIDTH-1:0]      wdata_i,
  input  logic [AW-1:0]         raddr_i,
  output logic [WIDTH-1:0]      rdata_o
);
  import bba_pkg::*;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.rd_en) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== dv/bitmap_block_allocator_checker.sv =====
// Checker for the bitmap block allocator: tracks the block map, predicts each result word and compares.
`timescale 1ns / 1ps

module bitmap_block_allocator_checker
  import bba_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cmd_start_i,
  input  logic                busy_i,
  input  bba_cmd_t            cmd_i,
  input  logic                done_i,
  input  bba_result_t         result_i,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic [COUNT_W-1:0]  cfg_data_i,
  output int                  fail_count_o,
  output int                  pending_o,
  output int                  checked_o,
  output int                  full_seen_o
);

  localparam int unsigned MAP_WORDS = NUM_BLOCKS_DEF / WORD_BITS_DEF;

  bit [WORD_BITS_DEF-1:0] map_words [MAP_WORDS];
  logic [COUNT_W-1:0]     managed_blocks;
  logic [COUNT_W-1:0]     blocks_held;
  bba_result_t            awaited_results [$];
  int                     failures;
  int                     checked;
  int                     full_seen;

  // Applies one command to the tracked map and returns the word the block should answer with.
  function automatic bba_result_t apply_command(bba_cmd_t c);
    bba_result_t r;
    int unsigned lim;
    int unsigned b;
    lim = (managed_blocks > NUM_BLOCKS_DEF) ? NUM_BLOCKS_DEF : int'(managed_blocks);
    r.result_block = c.block_index;
    r.status       = STAT_OK;
    r.block_used   = 1'b0;
    if (c.cmd == CMD_ALLOC) begin
      // First fit: whole used words are skipped at once, the scan stops at the managed limit.
      b = 0;
      while (b < lim && map_words[b / WORD_BITS_DEF][b % WORD_BITS_DEF]) begin
        if (b % WORD_BITS_DEF == 0 && &map_words[b / WORD_BITS_DEF]) begin
          b += WORD_BITS_DEF;
        end else begin
          b++;
        end
      end
      if (b < lim) begin
        map_words[b / WORD_BITS_DEF][b % WORD_BITS_DEF] = 1'b1;
        blocks_held    = blocks_held + 1'b1;
        r.result_block = b[BLOCK_W-1:0];
        r.block_used   = 1'b1;
      end else begin
        r.result_block = '0;
        r.status       = STAT_FULL;
      end
    end else if (c.block_index >= lim) begin
      r.status = STAT_RANGE;
    end else if (c.cmd == CMD_FREE) begin
      b = c.block_index;
      if (map_words[b / WORD_BITS_DEF][b % WORD_BITS_DEF]) begin
        map_words[b / WORD_BITS_DEF][b % WORD_BITS_DEF] = 1'b0;
        if (blocks_held != 0) begin
          blocks_held = blocks_held - 1'b1;
        end
      end else begin
        r.status = STAT_FREED;
      end
    end else begin
      b = c.block_index;
      r.block_used = map_words[b / WORD_BITS_DEF][b % WORD_BITS_DEF];
    end
    r.used_count = blocks_held;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    bba_result_t want;
    if (!rst_ni) begin
      for (int w = 0; w < MAP_WORDS; w++) begin
        map_words[w] = '0;
      end
      managed_blocks = MANAGED_RESET;
      blocks_held    = '0;
      awaited_results.delete();
      failures       = 0;
      checked        = 0;
      full_seen      = 0;
    end else begin
      if (done_i) begin
        if (awaited_results.size() == 0) begin
          if (failures < 10) begin
            $display("%0t: result word with no command waiting: block %0d status %0d",
                     $realtime, result_i.result_block, result_i.status);
          end
          failures++;
        end else begin
          want = awaited_results.pop_front();
          checked++;
          if (result_i.status == STAT_FULL) begin
            full_seen++;
          end
          if (result_i.result_block !== want.result_block || result_i.status !== want.status ||
              result_i.block_used !== want.block_used ||
              result_i.used_count !== want.used_count) begin
            if (failures < 10) begin
              $display("%0t: mismatch, expected block %0d status %0d used %0b count %0d,",
                       $realtime, want.result_block, want.status, want.block_used,
                       want.used_count);
              $display("  got block %0d status %0d used %0b count %0d",
                       result_i.result_block, result_i.status, result_i.block_used,
                       result_i.used_count);
            end
            failures++;
          end
        end
      end
      if (cmd_start_i && !busy_i) begin
        awaited_results.push_back(apply_command(cmd_i));
      end
      if (cfg_valid_i && cfg_ready_i) begin
        managed_blocks = cfg_data_i;
      end
    end
    fail_count_o <= failures;
    pending_o    <= awaited_results.size();
    checked_o    <= checked;
    full_seen_o  <= full_seen;
  end

endmodule

// ===== dv/bitmap_block_allocator_unit_tb.sv =====
// Testbench top for the bitmap block allocator: drives commands and settings, gives the verdict.
`timescale 1ns / 1ps

module bitmap_block_allocator_unit_tb;
  import bba_pkg::*;

  localparam logic [CMD_W-1:0] CMD_SPARE    = 2'd3;
  localparam int unsigned      RANDOM_ITEMS = 950;
  localparam int unsigned      CYCLE_LIMIT  = 400000;

  logic               clk_i     = 1'b0;
  logic               rst_ni    = 1'b0;
  logic               cmd_start = 1'b0;
  logic               dut_busy;
  bba_cmd_t           cmd_word  = '0;
  logic               res_done;
  bba_result_t        res_word;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [COUNT_W-1:0] cfg_value = '0;

  int                 fail_count;
  int                 pending;
  int                 checked;
  int                 full_seen;
  int unsigned        cycle_count = 0;
  int unsigned        commands_sent = 0;
  int unsigned        settings_written = 0;
  int unsigned        eff_limit = NUM_BLOCKS_DEF;

  bitmap_block_allocator_unit uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (cmd_start),
    .busy        (dut_busy),
    .cmd_i       (cmd_word),
    .done_o      (res_done),
    .result_o    (res_word),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_value)
  );

  bitmap_block_allocator_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_start_i  (cmd_start),
    .busy_i       (dut_busy),
    .cmd_i        (cmd_word),
    .done_i       (res_done),
    .result_i     (res_word),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_data_i   (cfg_value),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked),
    .full_seen_o  (full_seen)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d results outstanding", cycle_count, pending);
      $display("bitmap_block_allocator_unit_tb NOT OK");
      $finish;
    end
  end

  function automatic bba_cmd_t make_cmd(logic [CMD_W-1:0] op, logic [BLOCK_W-1:0] ix);
    bba_cmd_t c;
    c.cmd         = op;
    c.block_index = ix;
    return c;
  endfunction

  // Most indices land in the low region where allocated blocks gather, the rest spread wide
  // or sit on the edges of the managed range and of the index field.
  function automatic logic [BLOCK_W-1:0] pick_block(int unsigned lim);
    int unsigned sel;
    int unsigned span;
    sel  = $urandom_range(0, 99);
    span = ((lim < 512) ? lim : 512) + 4;
    if (sel < 55) begin
      return BLOCK_W'($urandom_range(0, span));
    end else if (sel < 80) begin
      return BLOCK_W'($urandom);
    end else if (sel < 90) begin
      return BLOCK_W'(20'hFFFFF - $urandom_range(0, 3));
    end else begin
      return BLOCK_W'(lim + $urandom_range(0, 2) - 1);
    end
  endfunction

  function automatic bba_cmd_t pick_command(int unsigned lim);
    int unsigned sel;
    logic [CMD_W-1:0] op;
    sel = $urandom_range(0, 99);
    if (sel < 40) begin
      op = CMD_ALLOC;
    end else if (sel < 70) begin
      op = CMD_FREE;
    end else if (sel < 95) begin
      op = CMD_TEST;
    end else begin
      op = CMD_SPARE;
    end
    return make_cmd(op, pick_block(lim));
  endfunction

  // Waits the given gap, then holds start until the block takes the word.
  task automatic send(input bba_cmd_t c, input int unsigned gap);
    if (gap != 0) begin
      cmd_start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cmd_start <= 1'b1;
    cmd_word  <= c;
    do @(posedge clk_i); while (dut_busy);
    commands_sent++;
  endtask

  // The extra edge lets the checker count a command taken at the current edge.
  task automatic drain();
    cmd_start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic set_managed(input logic [COUNT_W-1:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_value <= v;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    eff_limit = (v > NUM_BLOCKS_DEF) ? NUM_BLOCKS_DEF : int'(v);
    settings_written++;
  endtask

  function automatic logic [COUNT_W-1:0] pick_managed(int unsigned phase);
    case (phase % 8)
      0: return MANAGED_RESET;
      1: return COUNT_W'($urandom_range(1, 40));
      2: return COUNT_W'(64);
      3: return COUNT_W'($urandom_range(65, 300));
      4: return COUNT_W'(21'h1FFFFF);
      5: return COUNT_W'($urandom);
      6: return COUNT_W'(0);
      default: return COUNT_W'(1);
    endcase
  endfunction

  initial begin
    int unsigned phase;
    int unsigned items;
    int unsigned random_sent;
    bit          burst;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    // The block clears its map after reset and stays busy until done.
    while (dut_busy !== 1'b0) @(posedge clk_i);

    set_managed(MANAGED_RESET);
    send(make_cmd(CMD_TEST, 20'd0), 0);
    send(make_cmd(CMD_FREE, 20'd0), 0);
    send(make_cmd(CMD_TEST, 20'hFFFFF), 1);
    send(make_cmd(CMD_FREE, 20'hFFFFF), 0);
    send(make_cmd(CMD_ALLOC, 20'hFFFFF), 2);
    send(make_cmd(CMD_ALLOC, 20'd0), 0);
    send(make_cmd(CMD_TEST, 20'd0), 0);
    send(make_cmd(CMD_FREE, 20'd0), 3);
    send(make_cmd(CMD_ALLOC, 20'd7), 0);
    send(make_cmd(CMD_SPARE, 20'd1), 0);
    // Two managed blocks, both taken: the map reports full.
    set_managed(COUNT_W'(2));
    send(make_cmd(CMD_ALLOC, 20'd0), 0);
    send(make_cmd(CMD_TEST, 20'd2), 0);
    send(make_cmd(CMD_FREE, 20'd5), 1);
    send(make_cmd(CMD_FREE, 20'd1), 0);
    send(make_cmd(CMD_ALLOC, 20'd0), 0);
    // No managed blocks: an allocate reports full, test and free are out of range, the used ones stay counted.
    set_managed(COUNT_W'(0));
    send(make_cmd(CMD_ALLOC, 20'd0), 0);
    send(make_cmd(CMD_TEST, 20'd0), 0);
    send(make_cmd(CMD_FREE, 20'd0), 0);
    // A setting above the map size acts as the whole map.
    set_managed(COUNT_W'(21'h1FFFFF));
    send(make_cmd(CMD_ALLOC, 20'd0), 0);
    send(make_cmd(CMD_TEST, 20'hFFFFF), 0);
    send(make_cmd(CMD_FREE, 20'd2), 4);
    set_managed(COUNT_W'(1));
    send(make_cmd(CMD_ALLOC, 20'd0), 0);
    send(make_cmd(CMD_TEST, 20'd1), 0);

    phase       = 0;
    random_sent = 0;
    while (random_sent < RANDOM_ITEMS) begin
      set_managed(pick_managed(phase));
      items = $urandom_range(40, 80);
      burst = ($urandom_range(0, 2) == 0);
      for (int n = 0; n < items; n++) begin
        // Hold off once in the middle of a phase until every result word is back.
        if (phase == 3 && n == items / 2) begin
          drain();
        end
        send(pick_command(eff_limit), burst ? 0 : $urandom_range(0, 8));
        random_sent++;
      end
      phase++;
    end

    drain();
    repeat (16) @(posedge clk_i);
    $display("Sent %0d commands (%0d random) under %0d managed-block settings.",
             commands_sent, random_sent, settings_written);
    $display("Checked %0d result words, %0d of them full-map answers.", checked, full_seen);
    if (fail_count == 0) begin
      $display("bitmap_block_allocator_unit_tb OK");
    end else begin
      $display("%0d failures", fail_count);
      $display("bitmap_block_allocator_unit_tb NOT OK");
    end
    $finish;
  end

endmodule
